[sv/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[sv/oaht_pkg.sv]
// Types and constants of the open addressing hash table.
`default_nettype none

package oaht_pkg;

  // Table geometry.
  localparam int SLOTS   = 256;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int LOAD_W  = CNT_W + 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 64;

  // Load bound: a set is rejected when 4 * (count + 1) exceeds this.
  localparam int LOAD_LIMIT = 3 * SLOTS;

  // Request operations.
  typedef enum logic [1:0] {
    FUNC_SET = 2'd0,
    FUNC_GET = 2'd1,
    FUNC_DEL = 2'd2
  } func_e;

  // Response status codes.
  typedef enum logic [1:0] {
    RESP_OK   = 2'd0,
    RESP_MISS = 2'd1,
    RESP_FULL = 2'd2
  } resp_e;

  // Slot states.
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_st_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_e;

  // One word of the slot store.
  typedef struct packed {
    slot_st_e           st;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } slot_t;

endpackage

`default_nettype wire

[sv/open_addressing_hash_table.sv]
// Top level of the linear probing hash table with tombstones.
//
//  channel   | signals                                        | flow
//  ----------+------------------------------------------------+----------------------------
//  request   | start_i, func_i, key_id_i, key_hash_i,         | taken when start_i & !busy_o
//            | value_in_i                                     |
//  response  | done_o, status_o, is_new_key_o, value_out_o    | one-cycle strobe, no stall
//
// A request that needs no probe (unknown operation, set on a full table, get or
// delete on an empty table) answers in the next cycle. Otherwise the probe reads
// one slot per cycle through the single read port of the slot store, and the
// response follows once the probe has visited k slots (1 to SLOTS). After reset
// the block clears every slot of the store with busy_o high. The response cannot
// be stalled; busy_o is low in its cycle.
`default_nettype none

module open_addressing_hash_table
  import oaht_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       func_i,
  input  wire logic [KEY_W-1:0] key_id_i,
  input  wire logic [KEY_W-1:0] key_hash_i,
  input  wire logic [VAL_W-1:0] value_in_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic                  is_new_key_o,
  output logic [VAL_W-1:0]      value_out_o
);

  // Slot store, one write and one registered read per cycle.
  slot_t            mem [SLOTS];
  slot_t            rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;

  // Sequencer and probe registers.
  state_e           state_q, state_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic [IDX_W-1:0] data_idx_q, data_idx_d;
  logic [IDX_W-1:0] n_q, n_d;
  logic [IDX_W-1:0] tomb_q, tomb_d;
  logic             have_tomb_q, have_tomb_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Latched request.
  func_e            func_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // Response registers.
  logic             done_q, done_d;
  resp_e            status_q, status_d;
  logic             is_new_q, is_new_d;
  logic [VAL_W-1:0] vout_q, vout_d;

  // Probe evaluation signals.
  logic             accept;
  logic             table_full;
  logic             hit;
  logic             at_empty;
  logic             last;
  logic             have_tomb_now;
  logic [IDX_W-1:0] tomb_now;
  logic [IDX_W-1:0] target;
  logic             target_empty;
  logic [IDX_W-1:0] hash_idx;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign hash_idx = key_hash_i[IDX_W-1:0];
  assign table_full =
    ({2'b00, count_q + CNT_W'(1)} << 2) > LOAD_W'(LOAD_LIMIT);

  // Slot store write and read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  // Classify the slot that the previous cycle read.
  always_comb begin
    hit           = 1'b0;
    at_empty      = 1'b0;
    have_tomb_now = have_tomb_q;
    tomb_now      = tomb_q;
    case (rd_q.st)
      SLOT_USED: begin
        hit = (rd_q.key == key_q);
      end
      SLOT_TOMB: begin
        if (!have_tomb_q) begin
          have_tomb_now = 1'b1;
          tomb_now      = data_idx_q;
        end
      end
      default: begin
        at_empty = 1'b1;
      end
    endcase
    last = (n_q == {IDX_W{1'b1}});
    if (at_empty) begin
      target       = have_tomb_now ? tomb_now : data_idx_q;
      target_empty = !have_tomb_now;
    end else if (hit) begin
      target       = data_idx_q;
      target_empty = 1'b0;
    end else begin
      // Probe ran over every slot without meeting an empty one.
      target       = have_tomb_now ? tomb_now : data_idx_q + IDX_W'(1);
      target_empty = 1'b0;
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      data_idx_q  <= '0;
      n_q         <= '0;
      tomb_q      <= '0;
      have_tomb_q <= 1'b0;
      count_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      data_idx_q  <= data_idx_d;
      n_q         <= n_d;
      tomb_q      <= tomb_d;
      have_tomb_q <= have_tomb_d;
      count_q     <= count_d;
      done_q      <= done_d;
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      key_q  <= key_id_i;
      val_q  <= value_in_i;
    end
    status_q <= status_d;
    is_new_q <= is_new_d;
    vout_q   <= vout_d;
  end

  // Next state, store writes and response.
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    data_idx_d  = data_idx_q;
    n_d         = n_q;
    tomb_d      = tomb_q;
    have_tomb_d = have_tomb_q;
    count_d     = count_q;
    done_d      = 1'b0;
    status_d    = status_q;
    is_new_d    = is_new_q;
    vout_d      = vout_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = '{st: SLOT_EMPTY, key: '0, value: '0};
    rd_addr     = addr_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        addr_d = addr_q + IDX_W'(1);
        if (addr_q == {IDX_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        rd_addr     = hash_idx;
        addr_d      = hash_idx + IDX_W'(1);
        data_idx_d  = hash_idx;
        n_d         = '0;
        have_tomb_d = 1'b0;
        if (accept) begin
          status_d = RESP_MISS;
          is_new_d = 1'b0;
          vout_d   = '0;
          case (func_e'(func_i))
            FUNC_SET: begin
              if (table_full) begin
                status_d = RESP_FULL;
                done_d   = 1'b1;
              end else begin
                state_d = ST_PROBE;
              end
            end
            FUNC_GET, FUNC_DEL: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = ST_PROBE;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_PROBE: begin
        if (hit || at_empty || last) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = RESP_MISS;
          is_new_d = 1'b0;
          vout_d   = '0;
          case (func_q)
            FUNC_SET: begin
              mem_we    = 1'b1;
              mem_waddr = target;
              mem_wdata = '{st: SLOT_USED, key: key_q, value: val_q};
              status_d  = RESP_OK;
              is_new_d  = !hit;
              if (!hit && target_empty) begin
                count_d = count_q + CNT_W'(1);
              end
            end
            FUNC_GET: begin
              if (hit) begin
                status_d = RESP_OK;
                vout_d   = rd_q.value;
              end
            end
            FUNC_DEL: begin
              if (hit) begin
                mem_we    = 1'b1;
                mem_waddr = data_idx_q;
                mem_wdata = '{st: SLOT_TOMB, key: rd_q.key, value: rd_q.value};
                status_d  = RESP_OK;
              end
            end
            default: begin
              status_d = RESP_MISS;
            end
          endcase
        end else begin
          // Step to the next slot, whose read is already in flight.
          data_idx_d  = addr_q;
          addr_d      = addr_q + IDX_W'(1);
          n_d         = n_q + IDX_W'(1);
          tomb_d      = tomb_now;
          have_tomb_d = have_tomb_now;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign is_new_key_o = is_new_q;
  assign value_out_o  = vout_q;

endmodule

`default_nettype wire

[sv/oaht_checker.sv]
// Port-level checker for the hash table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module oaht_checker
  import oaht_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire logic             done_o,
  input wire logic [1:0]       status_o,
  input wire logic             is_new_key_o,
  input wire logic [VAL_W-1:0] value_out_o
);

  // A response lands in a cycle where a new transaction can be taken.
  `ASSERT_SAME(a_done_not_busy, clk_i, rst_ni, done_o, !busy_o)

  // An idle cycle without a transaction produces no response.
  `ASSERT_NEXT(a_no_spurious_done, clk_i, rst_ni, !busy_o && !start_i, !done_o)

  // Only a successful lookup carries a value.
  `ASSERT_SAME(a_value_on_ok, clk_i, rst_ni,
               done_o && (status_o != RESP_OK), value_out_o == '0)

  // A new key is only reported by a completed set.
  `ASSERT_SAME(a_new_key_ok, clk_i, rst_ni,
               done_o && is_new_key_o, (status_o == RESP_OK) && (value_out_o == '0))

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);

`default_nettype wire
